>>> sv/crlf_pkg.sv
package crlf_pkg;

	localparam logic [7:0] BYTE_CR = 8'h0D;
	localparam logic [7:0] BYTE_LF = 8'h0A;

	// Most payload words a frame can carry out
	localparam int MAX_WORDS = 8;
	localparam int WORD_BITS = 32;
	localparam int FRAME_BITS = MAX_WORDS * WORD_BITS;

	typedef enum logic [4:0] {
		PH_HUNT     = 5'b00001,
		PH_LF       = 5'b00010,
		PH_DATA     = 5'b00100,
		PH_TRAIL_LF = 5'b01000,
		PH_TRAIL_CR = 5'b10000
	} phase_t;

	typedef logic [FRAME_BITS-1:0] frame_t;

	// Status from the parser to the top level and the output buffer
	typedef struct packed {
		logic trail_cr;  // parser waits for the closing CR
		logic emit;      // good trailer taken this cycle
	} parse_stat_t;

endpackage

>>> sv/crlf_parse.sv
module crlf_parse #(
	parameter int PAYLOAD_BYTES = 32,
	parameter int NWORDS        = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rx_fire,
	input  logic [7:0]           rx_byte,
	output crlf_pkg::parse_stat_t stat,
	output crlf_pkg::frame_t     frame
);
	import crlf_pkg::*;

	localparam int PW     = $clog2(PAYLOAD_BYTES);
	localparam int NBYTES = NWORDS * 4;

	phase_t          phase_q;
	logic [PW-1:0]   pos_q;
	logic [7:0]      store_q [NBYTES];

	// Update the phase and the byte position on every accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			pos_q   <= '0;
		end else if (rx_fire) begin
			unique case (phase_q)
				PH_HUNT: begin
					phase_q <= (rx_byte == BYTE_CR) ? PH_LF : PH_HUNT;
				end
				PH_LF: begin
					if (rx_byte == BYTE_LF) begin
						pos_q   <= '0;
						phase_q <= PH_DATA;
					end else if (rx_byte != BYTE_CR) begin
						phase_q <= PH_HUNT;
					end
				end
				PH_DATA: begin
					if (pos_q == PW'(PAYLOAD_BYTES - 1)) begin
						pos_q   <= '0;
						phase_q <= PH_TRAIL_LF;
					end else begin
						pos_q <= pos_q + 1'b1;
					end
				end
				PH_TRAIL_LF: begin
					phase_q <= (rx_byte == BYTE_LF) ? PH_TRAIL_CR : PH_HUNT;
				end
				PH_TRAIL_CR: begin
					phase_q <= PH_HUNT;
				end
				default: begin
					phase_q <= PH_HUNT;
				end
			endcase
		end
	end

	// Keep only the bytes that reach the output; the rest are dropped
	always_ff @(posedge clk) begin
		if (rx_fire && phase_q == PH_DATA) begin
			for (int b = 0; b < NBYTES; b++) begin
				if (pos_q == PW'(b)) begin
					store_q[b] <= rx_byte;
				end
			end
		end
	end

	assign stat.trail_cr = (phase_q == PH_TRAIL_CR);
	assign stat.emit     = rx_fire && (phase_q == PH_TRAIL_CR) && (rx_byte == BYTE_CR);

	// Little-endian packing: byte 4k sits in bits 7:0 of word k
	genvar w;
	generate
		for (w = 0; w < MAX_WORDS; w++) begin : g_word
			if (w < NWORDS) begin : g_used
				assign frame[w*WORD_BITS +: WORD_BITS] = {store_q[4*w+3], store_q[4*w+2],
				                                          store_q[4*w+1], store_q[4*w]};
			end else begin : g_unused
				assign frame[w*WORD_BITS +: WORD_BITS] = '0;
			end
		end
	endgenerate

endmodule

>>> sv/crlf_drain.sv
module crlf_drain #(
	parameter int NWORDS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 emit,
	input  crlf_pkg::frame_t     frame,
	output logic                 busy,
	output logic                 word_valid,
	input  logic                 word_ready,
	output logic [2:0]           word_index,
	output logic [31:0]          word_value,
	output logic                 last_word
);
	import crlf_pkg::*;

	logic [WORD_BITS-1:0] buf_q [MAX_WORDS];
	logic                 busy_q;
	logic [2:0]           idx_q;
	logic                 last;

	assign last = (idx_q == 3'(NWORDS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (emit) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q && word_ready) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// Take a copy of the frame so the parser can refill its store at once
	always_ff @(posedge clk) begin
		if (emit) begin
			for (int k = 0; k < MAX_WORDS; k++) begin
				buf_q[k] <= frame[k*WORD_BITS +: WORD_BITS];
			end
		end
	end

	assign busy       = busy_q;
	assign word_valid = busy_q;
	assign word_index = idx_q;
	assign word_value = buf_q[idx_q];
	assign last_word  = last;

endmodule

>>> sv/crlf_framed_payload_deframer.sv
// Byte-stream deframer: each accepted request on the rx channel is one received byte. The
// block hunts for CR LF (extra CRs before the LF are tolerated), stores PAYLOAD_BYTES bytes
// as plain data, then needs LF CR as trailer. A wrong byte drops the frame and returns to
// the hunt without looking at that byte again. On a good trailer the payload goes out as
// little-endian 32-bit words (at most eight, a partial trailing word is dropped), the final
// one flagged by last_word. One byte is taken every cycle while rx_ready is high: each byte
// needs one compare and a store write. The finished frame is copied into an output buffer, so
// the next frame can be received while words drain; rx_ready falls only while the parser waits
// for the closing byte of a frame and the previous frame is still waiting to be taken.
module crlf_framed_payload_deframer #(
	parameter int PAYLOAD_BYTES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_ready,
	input  logic [7:0]  rx_byte,
	output logic        word_valid,
	input  logic        word_ready,
	output logic [2:0]  word_index,
	output logic [31:0] word_value,
	output logic        last_word
);
	import crlf_pkg::*;

	// Whole words in the payload, capped at the output limit
	localparam int NWORDS = ((PAYLOAD_BYTES / 4) > MAX_WORDS) ? MAX_WORDS : (PAYLOAD_BYTES / 4);

	parse_stat_t stat;
	frame_t      frame;
	logic        busy;
	logic        rx_fire;

	// Hold the closing byte back while the output buffer still owns a frame
	assign rx_ready = !(stat.trail_cr && busy);
	assign rx_fire  = rx_valid && rx_ready;

	crlf_parse #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES),
		.NWORDS       (NWORDS)
	) u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.rx_fire(rx_fire),
		.rx_byte(rx_byte),
		.stat   (stat),
		.frame  (frame)
	);

	crlf_drain #(
		.NWORDS(NWORDS)
	) u_drain (
		.clk       (clk),
		.arst_n    (arst_n),
		.emit      (stat.emit),
		.frame     (frame),
		.busy      (busy),
		.word_valid(word_valid),
		.word_ready(word_ready),
		.word_index(word_index),
		.word_value(word_value),
		.last_word (last_word)
	);

endmodule
